[hdl/wmaa_pkg.sv]
`timescale 1ns / 1ps

package wmaa_pkg;

  // Field widths
  localparam int TICK_W   = 12;
  localparam int SAMPLE_W = 10;
  localparam int CHAN_W   = 3;
  localparam int AVG_W    = 10;
  localparam int SUM_W    = SAMPLE_W + TICK_W;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 4;

  // Channel store
  localparam int CHANNELS = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Default window: starts at 93 percent of a 3000-tick period
  localparam int START_PERCENT = 93;
  localparam int PERIOD_TICKS  = 3000;
  localparam int PERCENT_SCALE = 100;
  localparam int START_RESET   = PERIOD_TICKS * START_PERCENT / PERCENT_SCALE;
  localparam int OUT_MAX       = 1023;

  // Item functions
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ONCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  // Measurement modes
  localparam logic [1:0] MODE_REQ   = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_CYCLE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 4'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mux_channel;
    logic              window_done;
    logic              done_was_once;
    logic [CHAN_W-1:0] done_channel;
    logic [AVG_W-1:0]  done_average;
    logic              once_busy;
    logic [AVG_W-1:0]  once_value;
    logic [AVG_W-1:0]  read_value;
  } out_item_t;

  // Saturate a quotient to the output range
  function automatic logic [AVG_W-1:0] clamp_avg(input logic [SUM_W-1:0] v);
    logic [AVG_W-1:0] r;
    if (v > SUM_W'(OUT_MAX)) begin
      r = AVG_W'(OUT_MAX);
    end else begin
      r = v[AVG_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/wmaa_in_if.sv]
`timescale 1ns / 1ps

interface wmaa_in_if import wmaa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/wmaa_out_if.sv]
`timescale 1ns / 1ps

interface wmaa_out_if import wmaa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/wmaa_cfg_if.sv]
`timescale 1ns / 1ps

interface wmaa_cfg_if import wmaa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/windowed_mux_adc_averager_unit.sv]
`timescale 1ns / 1ps

// Multiplexed ADC window averager. Each item is a millisecond tick carrying a
// converter sample, a one-shot request for a channel, or a read of a channel's
// stored average; every item gives exactly one result. Ticks, requests and
// reads pass straight to the output register. A tick that closes a
// measurement window is accepted and then starts the bit-serial restoring
// divider that forms sum / count one quotient bit per cycle. A new item is
// accepted while the previous result is being taken. Configuration writes
// (window start and end tick) are always ready and take effect at once.
module windowed_mux_adc_averager_unit import wmaa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmaa_cfg_if.sink   cfg_i,
  wmaa_in_if.sink    in_i,
  wmaa_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 state_q, state_d;
  logic [TICK_W-1:0]    start_q, start_d;
  logic [TICK_W-1:0]    end_q, end_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [TICK_W-1:0]    cnt_q, cnt_d;
  logic [CHAN_W-1:0]    cur_q, cur_d;
  logic [1:0]           mode_q, mode_d;
  logic [AVG_W-1:0]     avg_q [CHANNELS];
  logic [AVG_W-1:0]     avg_d [CHANNELS];
  logic [AVG_W-1:0]     once_q, once_d;
  logic [SUM_W-1:0]     div_q, div_d;
  logic [TICK_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 pend_once_q, pend_once_d;
  logic [CH_IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 in_fire;
  logic                 end_tick;
  logic [AVG_W-1:0]     rd_val;
  logic [TICK_W:0]      partial;
  logic [TICK_W:0]      diff;
  logic                 q_bit;
  logic [SUM_W-1:0]     quot;
  logic [AVG_W-1:0]     avg_res;
  out_item_t            res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Divider datapath: one restoring step per cycle
  assign partial = {rem_q, div_q[SUM_W-1]};
  assign diff    = partial - {1'b0, cnt_q};
  assign q_bit   = (partial >= {1'b0, cnt_q});
  assign quot    = {div_q[SUM_W-2:0], q_bit};
  assign avg_res = (cnt_q == '0) ? '0 : clamp_avg(quot);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    end_d       = end_q;
    tick_d      = tick_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    mode_d      = mode_q;
    avg_d       = avg_q;
    once_d      = once_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    pend_once_d = pend_once_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    end_tick    = 1'b0;
    rd_val      = '0;
    res         = '0;

    // Register writes
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START: start_d = cfg_i.data;
        REG_END:   end_d   = cfg_i.data;
        default:   ;
      endcase
    end

    if (in_fire) begin
      case (in_i.data.func)
        FUNC_TICK: begin
          if (mode_q != MODE_REQ) begin
            if (tick_q == '0) begin
              // period start: clear accumulator, fold channel into range
              sum_d  = '0;
              cnt_d  = '0;
              cur_d  = CHAN_W'(cur_q % CHANNELS);
              tick_d = TICK_W'(1);
            end else if (tick_q >= end_q) begin
              end_tick = 1'b1;
              tick_d   = '0;
              if (mode_q == MODE_RUN) begin
                mode_d = MODE_CYCLE;
              end else begin
                cur_d = cur_q + 1'b1;
              end
            end else begin
              if (tick_q >= start_q) begin
                sum_d = sum_q + SUM_W'(in_i.data.sample);
                cnt_d = cnt_q + 1'b1;
              end
              tick_d = tick_q + 1'b1;
            end
          end else begin
            // arming tick of a one-shot
            mode_d = MODE_RUN;
            tick_d = '0;
          end
        end
        FUNC_ONCE: begin
          cur_d  = in_i.data.channel;
          mode_d = MODE_REQ;
        end
        FUNC_READ: begin
          if (32'(in_i.data.channel) < CHANNELS) begin
            rd_val = avg_q[CH_IDX_W'(in_i.data.channel)];
          end
        end
        default: ;
      endcase

      res.mux_channel = cur_d;
      res.once_busy   = (mode_d != MODE_CYCLE);
      res.once_value  = once_q;
      res.read_value  = rd_val;

      if (end_tick) begin
        res.window_done   = 1'b1;
        res.done_was_once = (mode_q == MODE_RUN);
        res.done_channel  = cur_q;
        pend_once_d       = (mode_q == MODE_RUN);
        pend_idx_d        = CH_IDX_W'(cur_q % CHANNELS);
        div_d             = sum_q;
        rem_d             = '0;
        step_d            = '0;
        state_d           = ST_DIV;
      end else begin
        out_valid_d = 1'b1;
      end
      out_d = res;
    end

    // Serial division, result delivered on the last step
    if (state_q == ST_DIV) begin
      rem_d  = q_bit ? diff[TICK_W-1:0] : partial[TICK_W-1:0];
      div_d  = quot;
      step_d = step_q + 1'b1;
      if (step_q == DIV_CNT_W'(SUM_W - 1)) begin
        out_d.done_average = avg_res;
        if (pend_once_q) begin
          once_d           = avg_res;
          out_d.once_value = avg_res;
        end else begin
          avg_d[pend_idx_q] = avg_res;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= TICK_W'(START_RESET);
      end_q       <= TICK_W'(PERIOD_TICKS);
      tick_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      mode_q      <= MODE_CYCLE;
      avg_q       <= '{default: '0};
      once_q      <= '0;
      step_q      <= '0;
      pend_once_q <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      end_q       <= end_d;
      tick_q      <= tick_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      mode_q      <= mode_d;
      avg_q       <= avg_d;
      once_q      <= once_d;
      step_q      <= step_d;
      pend_once_q <= pend_once_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule
